@@ hdl/mbd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mbd_pkg
// shared types and constants of the mipmap 2x2 box downsampler
// ----------------------------------------------------------------------------
package mbd_pkg;

    localparam int PIX_W      = 32;
    localparam int PAIR_W     = 64;
    localparam int SW_W       = 13;
    localparam int SH_W       = 16;
    localparam int MODE_W     = 2;
    localparam int SLC_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT_MODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT = 3'd5;

    localparam logic [MODE_W-1:0] MODE_UNORM8   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SNORM8   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RGB10A2  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

    localparam logic [1:0] SEL_BOTH = 2'd0;
    localparam logic [1:0] SEL_HORZ = 2'd1;
    localparam logic [1:0] SEL_VERT = 2'd2;
    localparam logic [1:0] SEL_NONE = 2'd3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [SW_W-1:0]   src_width;
        logic [SH_W-1:0]   src_height;
        logic [SW_W-1:0]   dst_width;
        logic [SH_W-1:0]   dst_height;
        logic [MODE_W-1:0] mode;
        logic [SLC_W-1:0]  slice_count;
    } mbd_cfg_t;

    typedef struct packed {
        logic [3:0][PAIR_W-1:0] px;
        logic                   last;
        logic [MODE_W-1:0]      mode;
        logic                   two;
    } mbd_box_t;

endpackage
`default_nettype wire

@@ hdl/mbd_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mbd_front
// accepts source words, tracks position, keeps the even-row line store and
// gathers the four pixels of each finished box
// ----------------------------------------------------------------------------
module mbd_front #(
    parameter int MAX_SRC_WIDTH = 4096,
    parameter int MAX_SLICES    = 2
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire mbd_pkg::mbd_cfg_t       cfg,
    input  wire logic                    restart,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [mbd_pkg::PIX_W-1:0] pixel_first,
    input  wire logic [mbd_pkg::PIX_W-1:0] pixel_second,
    input  wire logic                    q_full,
    output logic                         push,
    output mbd_pkg::mbd_box_t            push_data
);
    import mbd_pkg::*;

    localparam int AW     = $clog2(MAX_SRC_WIDTH);
    localparam int SLOT_W = PIX_W * MAX_SLICES;

    logic [SLOT_W-1:0] row_store_mem [MAX_SRC_WIDTH];

    logic [SW_W-1:0]   col_reg, col_next;
    logic [SH_W-1:0]   row_reg, row_next;
    logic [SLOT_W-1:0] left_reg, left_next;

    logic              s1_valid_reg, s1_valid_next;
    logic [SLOT_W-1:0] s1_cur_reg;
    logic [SLOT_W-1:0] s1_left_reg;
    logic [SLOT_W-1:0] s1_prev_reg;
    logic [SLOT_W-1:0] s1_above_reg;
    logic [1:0]        s1_sel_reg;
    logic              s1_emit_reg;
    logic              s1_last_reg;
    logic [MODE_W-1:0] s1_mode_reg;
    logic              s1_two_reg;

    logic              accept;
    logic              advance;
    logic              hx, hy, two;
    logic [PAIR_W-1:0] cur_pair;
    logic [SLOT_W-1:0] cur_slot;
    logic              in_range;
    logic [SW_W-1:0]   dc;
    logic [SH_W-1:0]   dr;
    logic              done, emit, last;
    logic [1:0]        sel;
    logic [MODE_W-1:0] mode_eff;
    logic [SW_W-1:0]   src_w_eff;
    logic [SH_W-1:0]   src_h_eff;
    logic [AW-1:0]     addr_cur, addr_prev;
    logic              store_wr;
    logic [PAIR_W-1:0] p_cur, p_left, p_prev, p_above;

    assign accept   = in_valid && !in_stall;
    assign advance  = s1_valid_reg && !q_full;
    assign in_stall = s1_valid_reg && q_full;

    assign hx       = cfg.dst_width != cfg.src_width;
    assign hy       = cfg.dst_height != cfg.src_height;
    assign two      = (MAX_SLICES > 1) && (cfg.slice_count > SLC_W'(1));
    assign cur_pair = {two ? pixel_second : {PIX_W{1'b0}}, pixel_first};
    assign cur_slot = SLOT_W'(cur_pair);
    assign in_range = 32'(col_reg) < MAX_SRC_WIDTH;

    assign dc   = hx ? {1'b0, col_reg[SW_W-1:1]} : col_reg;
    assign dr   = hy ? {1'b0, row_reg[SH_W-1:1]} : row_reg;
    assign done = (!hx || col_reg[0]) && (!hy || row_reg[0]);
    assign emit = in_range && done && (dc < cfg.dst_width) && (dr < cfg.dst_height);
    assign last = (({1'b0, dc} + (SW_W+1)'(1)) == {1'b0, cfg.dst_width})
               && (({1'b0, dr} + (SH_W+1)'(1)) == {1'b0, cfg.dst_height});

    assign mode_eff  = (cfg.mode == MODE_RESERVED) ? MODE_UNORM8 : cfg.mode;
    assign src_w_eff = (cfg.src_width == '0) ? SW_W'(1) : cfg.src_width;
    assign src_h_eff = (cfg.src_height == '0) ? SH_W'(1) : cfg.src_height;

    assign addr_cur  = AW'(col_reg);
    assign addr_prev = AW'(col_reg - SW_W'(1));
    assign store_wr  = accept && in_range && hy && !row_reg[0];

    always_comb
    begin
        case ({hx, hy})
            2'b11:   sel = SEL_BOTH;
            2'b10:   sel = SEL_HORZ;
            2'b01:   sel = SEL_VERT;
            default: sel = SEL_NONE;
        endcase
    end

    // position counters and left neighbor
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        if (restart)
        begin
            col_next  = '0;
            row_next  = '0;
            left_next = '0;
        end
        else if (accept)
        begin
            if (in_range)
            begin
                left_next = cur_slot;
            end
            if (({1'b0, col_reg} + (SW_W+1)'(1)) >= {1'b0, src_w_eff})
            begin
                col_next = '0;
                if (({1'b0, row_reg} + (SH_W+1)'(1)) >= {1'b0, src_h_eff})
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next = row_reg + SH_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + SW_W'(1);
            end
        end
    end

    assign s1_valid_next = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            left_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            left_reg     <= left_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // line store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            row_store_mem[addr_cur] <= cur_slot;
        end
        if (accept)
        begin
            s1_prev_reg  <= row_store_mem[addr_prev];
            s1_above_reg <= row_store_mem[addr_cur];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cur_reg  <= cur_slot;
            s1_left_reg <= left_reg;
            s1_sel_reg  <= sel;
            s1_emit_reg <= emit;
            s1_last_reg <= last;
            s1_mode_reg <= mode_eff;
            s1_two_reg  <= two;
        end
    end

    assign p_cur   = PAIR_W'(s1_cur_reg);
    assign p_left  = PAIR_W'(s1_left_reg);
    assign p_prev  = PAIR_W'(s1_prev_reg);
    assign p_above = PAIR_W'(s1_above_reg);

    always_comb
    begin
        push_data.last = s1_last_reg;
        push_data.mode = s1_mode_reg;
        push_data.two  = s1_two_reg;
        case (s1_sel_reg)
            SEL_BOTH:
            begin
                push_data.px[0] = p_prev;
                push_data.px[1] = p_above;
                push_data.px[2] = p_left;
                push_data.px[3] = p_cur;
            end
            SEL_HORZ:
            begin
                push_data.px[0] = p_left;
                push_data.px[1] = p_cur;
                push_data.px[2] = p_left;
                push_data.px[3] = p_cur;
            end
            SEL_VERT:
            begin
                push_data.px[0] = p_above;
                push_data.px[1] = p_above;
                push_data.px[2] = p_cur;
                push_data.px[3] = p_cur;
            end
            default:
            begin
                push_data.px[0] = p_cur;
                push_data.px[1] = p_cur;
                push_data.px[2] = p_cur;
                push_data.px[3] = p_cur;
            end
        endcase
    end

    assign push = advance && s1_emit_reg;

endmodule
`default_nettype wire

@@ hdl/mbd_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mbd_queue
// short box queue between the gather front and the filter back
// ----------------------------------------------------------------------------
module mbd_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire mbd_pkg::mbd_box_t push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   head_valid,
    output mbd_pkg::mbd_box_t      head_data
);
    import mbd_pkg::*;

    mbd_box_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

@@ hdl/mbd_filter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mbd_filter
// box filter arithmetic for the three formats and the output register
// ----------------------------------------------------------------------------
module mbd_filter (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      head_valid,
    input  wire mbd_pkg::mbd_box_t         head_data,
    output logic                           pop,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [mbd_pkg::PIX_W-1:0]      dest_pixel,
    output logic                           last_of_image
);
    import mbd_pkg::*;

    // quarter of a four-byte sum, low eight bits
    function automatic logic [7:0] quarter8(input logic [3:0][7:0] b, input logic sgn);
        logic [9:0] s;
        logic [9:0] t;
        s = '0;
        for (int k = 0; k < 4; k++)
        begin
            s = s + (sgn ? {{2{b[k][7]}}, b[k]} : {2'b00, b[k]});
        end
        t = s + ((sgn && s[9]) ? 10'd3 : 10'd0);
        return t[9:2];
    endfunction

    logic              out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]  dest_reg;
    logic              last_reg;
    logic [PIX_W-1:0]  result;

    always_comb
    begin
        logic [12:0]     sum_r, sum_g, sum_b;
        logic [4:0]      sum_a;
        logic [PIX_W-1:0] p;
        logic [3:0][7:0] b0, b1;
        logic [PIX_W-1:0] r8;
        logic [PIX_W-1:0] r10;
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        sum_a = '0;
        for (int s = 0; s < 2; s++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                p     = head_data.px[k][s*PIX_W +: PIX_W];
                sum_r = sum_r + 13'(p[9:0]);
                sum_g = sum_g + 13'(p[19:10]);
                sum_b = sum_b + 13'(p[29:20]);
                sum_a = sum_a + 5'(p[31:30]);
            end
        end
        if (head_data.two)
        begin
            r10 = {sum_a[4:3], sum_b[12:3], sum_g[12:3], sum_r[12:3]};
        end
        else
        begin
            r10 = {sum_a[3:2], sum_b[11:2], sum_g[11:2], sum_r[11:2]};
        end
        for (int ch = 0; ch < 4; ch++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                b0[k] = head_data.px[k][8*ch +: 8];
                b1[k] = head_data.px[k][PIX_W + 8*ch +: 8];
            end
            r8[8*ch +: 8] = quarter8(b0, head_data.mode == MODE_SNORM8)
                          + quarter8(b1, head_data.mode == MODE_SNORM8);
        end
        result = (head_data.mode == MODE_RGB10A2) ? r10 : r8;
    end

    assign pop            = head_valid && (!out_valid_reg || !out_stall);
    assign out_valid_next = pop ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            dest_reg <= result;
            last_reg <= head_data.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign dest_pixel    = dest_reg;
    assign last_of_image = last_reg;

endmodule
`default_nettype wire

@@ hdl/mipmap_box_downsample_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mipmap_box_downsample_core
// 2x2 box filter that builds one mip level from the previous one
// ----------------------------------------------------------------------------
// Source words arrive in raster order, one per cycle when the output is not
// stalled; once the word completing a box is accepted, its result passes the
// line store read register, the box queue, then the filter and output
// register. The even source row is kept in an on-chip line store of
// MAX_SRC_WIDTH entries with one write port and two read ports; it is not
// cleared and its contents are only used in odd rows after the even row wrote
// it. Register writes restart the position counters and must be issued while
// the block is idle.
module mipmap_box_downsample_core #(
    parameter int MAX_SRC_WIDTH = 4096,
    parameter int MAX_SLICES    = 2
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [mbd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mbd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [mbd_pkg::PIX_W-1:0]        pixel_first,
    input  wire logic [mbd_pkg::PIX_W-1:0]        pixel_second,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [mbd_pkg::PIX_W-1:0]             dest_pixel,
    output logic                                  last_of_image
);
    import mbd_pkg::*;

    mbd_cfg_t cfg_reg, cfg_next;
    logic     restart;
    logic     q_full, push, pop, head_valid;
    mbd_box_t push_data, head_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        restart  = 1'b0;
        if (cfg_write)
        begin
            restart = 1'b1;
            case (cfg_index)
                REG_SRC_WIDTH:   cfg_next.src_width   = cfg_data[SW_W-1:0];
                REG_SRC_HEIGHT:  cfg_next.src_height  = cfg_data[SH_W-1:0];
                REG_DST_WIDTH:   cfg_next.dst_width   = cfg_data[SW_W-1:0];
                REG_DST_HEIGHT:  cfg_next.dst_height  = cfg_data[SH_W-1:0];
                REG_FORMAT_MODE: cfg_next.mode        = cfg_data[MODE_W-1:0];
                REG_SLICE_COUNT: cfg_next.slice_count = cfg_data[SLC_W-1:0];
                default:         restart              = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width   <= SW_W'(1);
            cfg_reg.src_height  <= SH_W'(1);
            cfg_reg.dst_width   <= SW_W'(1);
            cfg_reg.dst_height  <= SH_W'(1);
            cfg_reg.mode        <= MODE_UNORM8;
            cfg_reg.slice_count <= SLC_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mbd_front #(
        .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
        .MAX_SLICES    (MAX_SLICES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .restart      (restart),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_first  (pixel_first),
        .pixel_second (pixel_second),
        .q_full       (q_full),
        .push         (push),
        .push_data    (push_data)
    );

    mbd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    mbd_filter u_filter (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_data     (head_data),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .dest_pixel    (dest_pixel),
        .last_of_image (last_of_image)
    );

endmodule
`default_nettype wire

@@ hdl/mbd_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mbd_checker
// port-level checks of the downsampler, bound to the top level
// ----------------------------------------------------------------------------
module mbd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] dest_pixel,
    input wire logic        last_of_image
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(dest_pixel)
                                   && $stable(last_of_image))
        else $error("stalled output word changed");

    // a fresh result must follow an accepted input word
    a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 3))
        else $error("output word without matching input");

    // input stall only while a word is held in the front stage
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> $past(in_valid && !in_stall) || $past(in_stall))
        else $error("input stall without held word");

endmodule

bind mipmap_box_downsample_core mbd_checker u_mbd_checker (.*);
`default_nettype wire
